// File: rtl/core/hlfm_pkg.sv
// Package for the heater load fault monitor: widths, codes, item and control types.
`timescale 1ns / 1ps
package hlfm_pkg;

  localparam int VOLT_BITS = 13;
  localparam int RES_BITS  = 16;
  localparam int REG_W     = 16;
  localparam int RUN_W     = 4;
  localparam int OFF_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int RES_OUT_W = 16;

  localparam int SUM_W  = VOLT_BITS + 1;
  localparam int NUM_W  = SUM_W + REG_W;
  localparam int SAT_W  = VOLT_BITS + RES_BITS;
  localparam int CMP_W  = (NUM_W > SAT_W) ? NUM_W : SAT_W;
  localparam int RCMP_W = (RES_BITS > REG_W) ? RES_BITS : REG_W;
  localparam int CNT_W  = $clog2(RES_BITS);

  localparam logic [RES_BITS-1:0] RES_MAX = {RES_BITS{1'b1}};
  localparam logic [RUN_W-1:0]    RUN_MAX = {RUN_W{1'b1}};

  localparam logic [REG_W-1:0] REF_RESET      = REG_W'(1000);
  localparam logic [REG_W-1:0] SHORT_RESET    = REG_W'(100);
  localparam logic [REG_W-1:0] OPEN_RESET     = REG_W'(5000);
  localparam logic [REG_W-1:0] OVERHEAT_RESET = REG_W'(2000);
  localparam logic [RUN_W-1:0] RUN_RESET      = RUN_W'(5);
  localparam logic [OFF_W-1:0] OFFSET_RESET   = OFF_W'(23);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF      = 3'd0,
    CFG_SHORT    = 3'd1,
    CFG_OPEN     = 3'd2,
    CFG_OVERHEAT = 3'd3,
    CFG_RUN      = 3'd4,
    CFG_OFFSET   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_NORMAL   = 2'd0,
    ST_SHORT    = 2'd1,
    ST_OPEN     = 2'd2,
    ST_OVERHEAT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SETUP,
    S_DIV,
    S_DECIDE,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic                 firing;
    logic [VOLT_BITS-1:0] load_mv;
    logic [VOLT_BITS-1:0] supply_mv;
    logic [VOLT_BITS-1:0] load_retry_mv;
    logic [VOLT_BITS-1:0] supply_retry_mv;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [RES_OUT_W-1:0] resistance_mohm;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic setup;
    logic step;
    logic emit;
    logic retry;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic need_retry;
    logic out_busy;
  } stat_t;

endpackage

// File: rtl/core/hlfm_ctrl.sv
// Sequencer for the heater load fault monitor: passes, divider steps and result hand-off.
`timescale 1ns / 1ps
module hlfm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hlfm_pkg::stat_t      stat_i,
  output hlfm_pkg::cmd_t       cmd_o
);

  hlfm_pkg::state_e              state_q, state_d;
  logic                          retry_q, retry_d;
  logic [hlfm_pkg::CNT_W-1:0]    cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hlfm_pkg::S_IDLE: begin
        if (in_valid_i) state_d = hlfm_pkg::S_MUL;
      end
      hlfm_pkg::S_MUL: state_d = hlfm_pkg::S_SETUP;
      hlfm_pkg::S_SETUP: begin
        state_d = stat_i.skip ? hlfm_pkg::S_DECIDE : hlfm_pkg::S_DIV;
      end
      hlfm_pkg::S_DIV: begin
        if (cnt_q == hlfm_pkg::CNT_W'(hlfm_pkg::RES_BITS - 1)) state_d = hlfm_pkg::S_DECIDE;
      end
      hlfm_pkg::S_DECIDE: begin
        state_d = (!retry_q && stat_i.need_retry) ? hlfm_pkg::S_MUL : hlfm_pkg::S_EMIT;
      end
      hlfm_pkg::S_EMIT: begin
        if (!stat_i.out_busy) state_d = hlfm_pkg::S_IDLE;
      end
      default: state_d = hlfm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    retry_d = retry_q;
    cnt_d   = cnt_q;
    if (state_q == hlfm_pkg::S_IDLE && in_valid_i) retry_d = 1'b0;
    if (state_q == hlfm_pkg::S_DECIDE && stat_i.need_retry) retry_d = 1'b1;
    if (state_q == hlfm_pkg::S_SETUP) cnt_d = '0;
    if (state_q == hlfm_pkg::S_DIV) cnt_d = cnt_q + 1'b1;
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = (state_q == hlfm_pkg::S_IDLE) && in_valid_i;
    cmd_o.mul     = (state_q == hlfm_pkg::S_MUL);
    cmd_o.setup   = (state_q == hlfm_pkg::S_SETUP);
    cmd_o.step    = (state_q == hlfm_pkg::S_DIV);
    cmd_o.emit    = (state_q == hlfm_pkg::S_EMIT) && !stat_i.out_busy;
    cmd_o.retry   = retry_q;
    in_stall_o    = (state_q != hlfm_pkg::S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hlfm_pkg::S_IDLE;
      retry_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      retry_q <= retry_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: rtl/core/hlfm_dp.sv
// Datapath for the heater load fault monitor: config, multiplier, divider, checks, output register.
`timescale 1ns / 1ps
module hlfm_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hlfm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [hlfm_pkg::REG_W-1:0]          cfg_wdata_i,
  input  hlfm_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output hlfm_pkg::out_item_t                 out_item_o,
  input  hlfm_pkg::cmd_t                      cmd_i,
  output hlfm_pkg::stat_t                     stat_o
);

  localparam int V = hlfm_pkg::VOLT_BITS;
  localparam int R = hlfm_pkg::RES_BITS;

  logic [hlfm_pkg::REG_W-1:0] ref_q, short_q, open_q, hot_q;
  logic [hlfm_pkg::RUN_W-1:0] need_q;
  logic [hlfm_pkg::OFF_W-1:0] off_q;

  hlfm_pkg::in_item_t         item_q;
  logic [hlfm_pkg::NUM_W-1:0] prod_q;
  logic [V-1:0]               den_q;
  logic                       neg_q, zero_q;
  logic [V-1:0]               rem_q;
  logic [R-1:0]               q_q;
  logic [hlfm_pkg::RUN_W-1:0] run_q, run_d;
  logic                       out_valid_q;
  hlfm_pkg::out_item_t        out_item_q;

  logic [V-1:0]               ld, sp;
  logic [hlfm_pkg::OFF_W-1:0] off;
  logic [hlfm_pkg::SUM_W-1:0] sum;
  logic [hlfm_pkg::CMP_W-1:0] prod_ext, sat_lim, hi;
  logic                       ovf;
  logic [V:0]                 trial;
  logic                       ge;
  logic [hlfm_pkg::RCMP_W-1:0] res_x;
  logic                       hot;
  logic [hlfm_pkg::RUN_W-1:0] run_inc;
  hlfm_pkg::status_e          status;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q   <= hlfm_pkg::REF_RESET;
      short_q <= hlfm_pkg::SHORT_RESET;
      open_q  <= hlfm_pkg::OPEN_RESET;
      hot_q   <= hlfm_pkg::OVERHEAT_RESET;
      need_q  <= hlfm_pkg::RUN_RESET;
      off_q   <= hlfm_pkg::OFFSET_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hlfm_pkg::CFG_REF:      ref_q   <= cfg_wdata_i;
        hlfm_pkg::CFG_SHORT:    short_q <= cfg_wdata_i;
        hlfm_pkg::CFG_OPEN:     open_q  <= cfg_wdata_i;
        hlfm_pkg::CFG_OVERHEAT: hot_q   <= cfg_wdata_i;
        hlfm_pkg::CFG_RUN:      need_q  <= cfg_wdata_i[hlfm_pkg::RUN_W-1:0];
        hlfm_pkg::CFG_OFFSET:   off_q   <= cfg_wdata_i[hlfm_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ld       = cmd_i.retry ? item_q.load_retry_mv : item_q.load_mv;
    sp       = cmd_i.retry ? item_q.supply_retry_mv : item_q.supply_mv;
    off      = cmd_i.retry ? '0 : off_q;
    sum      = hlfm_pkg::SUM_W'(ld) + hlfm_pkg::SUM_W'(off);
    prod_ext = hlfm_pkg::CMP_W'(prod_q);
    sat_lim  = hlfm_pkg::CMP_W'(den_q) << R;
    hi       = prod_ext >> R;
    ovf      = zero_q || (prod_ext >= sat_lim);
    trial    = {rem_q, q_q[R-1]};
    ge       = trial >= {1'b0, den_q};
    res_x    = hlfm_pkg::RCMP_W'(q_q);
  end

  // multiplier, restoring divider
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_item_i;
    if (cmd_i.mul) begin
      prod_q <= hlfm_pkg::NUM_W'(sum) * hlfm_pkg::NUM_W'(ref_q);
      neg_q  <= sp < ld;
      zero_q <= sp == ld;
      den_q  <= sp - ld;
    end
    if (cmd_i.setup) begin
      if (neg_q) begin
        q_q <= '0;
      end else if (ovf) begin
        q_q <= hlfm_pkg::RES_MAX;
      end else begin
        q_q   <= prod_ext[R-1:0];
        rem_q <= hi[V-1:0];
      end
    end
    if (cmd_i.step) begin
      rem_q <= ge ? V'(trial - {1'b0, den_q}) : trial[V-1:0];
      q_q   <= {q_q[R-2:0], ge};
    end
  end

  // fault decision
  always_comb begin
    hot     = !neg_q && (res_x >= hlfm_pkg::RCMP_W'(hot_q));
    run_inc = (run_q < hlfm_pkg::RUN_MAX) ? run_q + 1'b1 : run_q;
    status  = hlfm_pkg::ST_NORMAL;
    run_d   = run_q;
    priority if (!item_q.firing) begin
      status = hlfm_pkg::ST_NORMAL;
    end else if (!cmd_i.retry && (neg_q || res_x <= hlfm_pkg::RCMP_W'(short_q))) begin
      status = hlfm_pkg::ST_SHORT;
    end else if (cmd_i.retry && !neg_q && res_x >= hlfm_pkg::RCMP_W'(open_q)) begin
      status = hlfm_pkg::ST_OPEN;
    end else if (hot) begin
      if (run_inc >= need_q) begin
        run_d  = '0;
        status = hlfm_pkg::ST_OVERHEAT;
      end else begin
        run_d = run_inc;
      end
    end else begin
      run_d = '0;
    end
  end

  always_comb begin
    stat_o.skip       = neg_q || ovf;
    stat_o.need_retry = item_q.firing && !neg_q
                        && (res_x > hlfm_pkg::RCMP_W'(short_q))
                        && (res_x >= hlfm_pkg::RCMP_W'(open_q));
    stat_o.out_busy   = out_valid_q && out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        run_q       <= run_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_item_q.status          <= status;
      out_item_q.resistance_mohm <= hlfm_pkg::RES_OUT_W'(q_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: rtl/core/heater_load_fault_monitor.sv
// Top level of the heater load fault monitor.
//
//   channel   direction  handshake                  content
//   in        input      in_valid_i / in_stall_o    in_item_i  (hlfm_pkg::in_item_t)
//   out       output     out_valid_o / out_stall_i  out_item_o (hlfm_pkg::out_item_t)
//   cfg       input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One item at a time. A pass is multiply, range check, then RES_BITS steps of the
// restoring divider (skipped for negative, zero or saturating denominators). An item with
// an open retry takes two passes; both run through the one shared divider.
// Reset is asynchronous and loads the register defaults and clears the too-hot count.
// A result waits in the output register; the next item is taken meanwhile and only its
// own hand-off waits on out_stall_i.
`timescale 1ns / 1ps
module heater_load_fault_monitor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hlfm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hlfm_pkg::REG_W-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  hlfm_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output hlfm_pkg::out_item_t             out_item_o
);

  hlfm_pkg::cmd_t  cmd;
  hlfm_pkg::stat_t stat;

  hlfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hlfm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// File: rtl/core/hlfm_checker.sv
// Port-level assertions for the heater load fault monitor, bound to the top level.
`timescale 1ns / 1ps
module hlfm_props (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input hlfm_pkg::out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("output item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled while an item is in work");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in work");

endmodule

bind heater_load_fault_monitor hlfm_props u_hlfm_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// File: test/hlfm_checker.sv
// Checker for the heater load fault monitor: predicts each result and compares it.
`timescale 1ns / 1ps
module hlfm_checker
  import hlfm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_item_t             in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_item_t            out_item_i,
  output int                   err_cnt_o,
  output int                   pending_o,
  output int                   checked_o
);

  logic [REG_W-1:0] ref_q;
  logic [REG_W-1:0] short_q;
  logic [REG_W-1:0] open_q;
  logic [REG_W-1:0] hot_q;
  logic [RUN_W-1:0] run_need_q;
  logic [OFF_W-1:0] off_q;
  logic [RUN_W-1:0] hot_run_q;

  out_item_t expected_q[$];
  out_item_t exp_r;

  function automatic logic [RES_BITS-1:0] divider_mohm(input logic [VOLT_BITS-1:0] lo_mv,
                                                        input logic [VOLT_BITS-1:0] hi_mv,
                                                        input logic [OFF_W-1:0] off_mv,
                                                        output logic negative);
    longint unsigned q;
    negative = 1'b0;
    if (hi_mv < lo_mv) begin
      negative = 1'b1;
      return '0;
    end
    if (hi_mv == lo_mv) return RES_MAX;
    q = ((longint'(lo_mv) + longint'(off_mv)) * longint'(ref_q)) /
        (longint'(hi_mv) - longint'(lo_mv));
    if (q > longint'(RES_MAX)) return RES_MAX;
    return q[RES_BITS-1:0];
  endfunction

  // Updates the too-hot count as a side effect.
  function automatic out_item_t predict_result(input in_item_t it);
    out_item_t r;
    logic neg;
    logic done;
    logic [RES_BITS-1:0] res;
    r.status = ST_NORMAL;
    done = 1'b0;
    res = divider_mohm(it.load_mv, it.supply_mv, off_q, neg);
    if (it.firing) begin
      if (neg || res <= short_q) begin
        r.status = ST_SHORT;
      end else begin
        if (res >= open_q) begin
          res = divider_mohm(it.load_retry_mv, it.supply_retry_mv, '0, neg);
          if (!neg && res >= open_q) begin
            r.status = ST_OPEN;
            done = 1'b1;
          end
        end
        if (!done) begin
          if (!neg && res >= hot_q) begin
            if (hot_run_q != RUN_MAX) hot_run_q = hot_run_q + 1'b1;
            if (hot_run_q >= run_need_q) begin
              hot_run_q = '0;
              r.status = ST_OVERHEAT;
            end
          end else begin
            hot_run_q = '0;
          end
        end
      end
    end
    r.resistance_mohm = res;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q = REF_RESET;
      short_q = SHORT_RESET;
      open_q = OPEN_RESET;
      hot_q = OVERHEAT_RESET;
      run_need_q = RUN_RESET;
      off_q = OFFSET_RESET;
      hot_run_q = '0;
      expected_q.delete();
      err_cnt_o = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_REF:      ref_q = cfg_wdata_i;
          CFG_SHORT:    short_q = cfg_wdata_i;
          CFG_OPEN:     open_q = cfg_wdata_i;
          CFG_OVERHEAT: hot_q = cfg_wdata_i;
          CFG_RUN:      run_need_q = cfg_wdata_i[RUN_W-1:0];
          CFG_OFFSET:   off_q = cfg_wdata_i[OFF_W-1:0];
          default:      ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          err_cnt_o++;
          $display("%0t: unexpected result, none pending: status %0d resistance %0d",
                   $time, out_item_i.status, out_item_i.resistance_mohm);
        end else begin
          exp_r = expected_q.pop_front();
          checked_o++;
          if (out_item_i.status !== exp_r.status) begin
            err_cnt_o++;
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, exp_r.status, out_item_i.status);
          end
          if (out_item_i.resistance_mohm !== exp_r.resistance_mohm) begin
            err_cnt_o++;
            $display("%0t: resistance mismatch: expected %0d actual %0d",
                     $time, exp_r.resistance_mohm, out_item_i.resistance_mohm);
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(predict_result(in_item_i));
      pending_o = expected_q.size();
    end
  end

endmodule

// File: test/tb_heater_load_fault_monitor.sv
// Testbench top for the heater load fault monitor: stimulus, register phases and verdict.
`timescale 1ns / 1ps
module tb_heater_load_fault_monitor;
  import hlfm_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 55;
  localparam int PHASES       = 9;
  localparam int VOLT_TOP     = (1 << VOLT_BITS) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(7);

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [REG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 in_taken = 1'b0;

  int   gap_pct = 0;
  int   stall_pct = 0;
  logic hold_req = 1'b0;
  int   hold_cnt = 0;
  int   cycles = 0;
  int   sent = 0;
  int   hot_burst = 0;
  int   fail_cnt;
  int   pending;
  int   checked;

  logic [REG_W-1:0] cur_ref = REF_RESET;
  logic [REG_W-1:0] cur_short = SHORT_RESET;
  logic [REG_W-1:0] cur_open = OPEN_RESET;
  logic [REG_W-1:0] cur_hot = OVERHEAT_RESET;
  logic [OFF_W-1:0] cur_off = OFFSET_RESET;

  heater_load_fault_monitor u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  hlfm_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .err_cnt_o   (fail_cnt),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) in_taken <= in_valid && !in_stall;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: one long hold-off once requested, random stalls otherwise.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && hold_cnt < HOLD_CYCLES) begin
        out_stall <= 1'b1;
        hold_cnt++;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(negedge clk); while (!in_taken);
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [REG_W-1:0] r_ref, input logic [REG_W-1:0] r_short,
                                input logic [REG_W-1:0] r_open, input logic [REG_W-1:0] r_hot,
                                input logic [RUN_W-1:0] r_run, input logic [OFF_W-1:0] r_off);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(CFG_REF, r_ref);
    write_reg(CFG_SHORT, r_short);
    write_reg(CFG_OPEN, r_open);
    write_reg(CFG_OVERHEAT, r_hot);
    write_reg(CFG_RUN, REG_W'(r_run));
    write_reg(CFG_OFFSET, REG_W'(r_off));
    write_reg(CFG_SPARE, REG_W'($urandom));
    cfg_we <= 1'b0;
    cur_ref = r_ref;
    cur_short = r_short;
    cur_open = r_open;
    cur_hot = r_hot;
    cur_off = r_off;
  endtask

  function automatic in_item_t reading(input logic f, input int l, input int s,
                                       input int lr, input int sr);
    in_item_t it;
    it.firing = f;
    it.load_mv = VOLT_BITS'(l);
    it.supply_mv = VOLT_BITS'(s);
    it.load_retry_mv = VOLT_BITS'(lr);
    it.supply_retry_mv = VOLT_BITS'(sr);
    return it;
  endfunction

  // Load/supply pair whose divider resistance lands near the target.
  function automatic logic [2*VOLT_BITS-1:0] divider_pair(input longint target, input int off);
    longint lo;
    longint span;
    longint d;
    lo = $urandom_range(0, VOLT_TOP - 1);
    span = VOLT_TOP - lo;
    d = (target <= 0) ? span : ((lo + off) * longint'(cur_ref)) / target;
    if (d < 1) d = 1;
    if (d > span) d = span;
    return {VOLT_BITS'(lo), VOLT_BITS'(lo + d)};
  endfunction

  function automatic longint pick_target();
    longint base;
    case ($urandom_range(0, 3))
      0:       base = cur_short;
      1:       base = cur_hot;
      2:       base = cur_open;
      default: base = $urandom_range(0, 65535);
    endcase
    return base + longint'($urandom_range(0, 400)) - 200;
  endfunction

  function automatic in_item_t random_reading();
    in_item_t it;
    logic [2*VOLT_BITS-1:0] pair;
    int k;
    int lo;
    k = $urandom_range(0, 99);
    it = '0;
    if (hot_burst > 0) begin
      hot_burst--;
      it.firing = 1'b1;
      pair = divider_pair(longint'(cur_hot) + $urandom_range(0, 300), cur_off);
      {it.load_mv, it.supply_mv} = pair;
      pair = divider_pair(longint'(cur_hot) + $urandom_range(0, 300), 0);
      {it.load_retry_mv, it.supply_retry_mv} = pair;
      return it;
    end
    if (k < 10) begin
      it = in_item_t'({$urandom, $urandom});
    end else begin
      if (k < 15) begin
        lo = $urandom_range(1, VOLT_TOP);
        it.load_mv = VOLT_BITS'(lo);
        it.supply_mv = VOLT_BITS'($urandom_range(0, lo - 1));
      end else if (k < 20) begin
        it.load_mv = VOLT_BITS'($urandom);
        it.supply_mv = it.load_mv;
      end else begin
        pair = divider_pair(pick_target(), cur_off);
        {it.load_mv, it.supply_mv} = pair;
      end
      if ($urandom_range(0, 99) < 80) begin
        pair = divider_pair(pick_target(), 0);
        {it.load_retry_mv, it.supply_retry_mv} = pair;
      end else begin
        it.load_retry_mv = VOLT_BITS'($urandom);
        it.supply_retry_mv = VOLT_BITS'($urandom);
      end
      it.firing = ($urandom_range(0, 99) < 85);
    end
    if (k >= 95) hot_burst = $urandom_range(1, 16);
    return it;
  endfunction

  initial begin
    int p;
    int i;
    int short_v;
    int hot_v;
    int open_v;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Directed readings at the reset register values.
    send_item(reading(1'b0, 0, 0, 0, 0));
    send_item(reading(1'b1, VOLT_TOP, VOLT_TOP, VOLT_TOP, VOLT_TOP));
    send_item(reading(1'b1, 0, VOLT_TOP, 0, 0));
    send_item(reading(1'b1, VOLT_TOP, 0, 0, 0));
    send_item(reading(1'b0, VOLT_TOP, 0, 0, 0));
    send_item(reading(1'b1, 4000, 4100, 4000, 4100));
    send_item(reading(1'b1, 4000, 4100, 1000, 2000));
    send_item(reading(1'b1, 4000, 4100, 2000, 1000));
    send_item(reading(1'b1, 4000, 4100, 3000, 4000));
    repeat (5) send_item(reading(1'b1, 2000, 3000, 0, 0));
    send_item(reading(1'b1, 77, 1077, 0, 0));
    send_item(reading(1'b1, 77, 1067, 0, 0));
    send_item(reading(1'b1, 4977, 5977, 4977, 5977));
    send_item(reading(1'b0, 4977, 5977, 4977, 5977));
    send_item(reading(1'b1, 8000, 8001, 0, VOLT_TOP));
    send_item(reading(1'b1, 0, 0, 0, VOLT_TOP));
    send_item(reading(1'b1, 0, 0, VOLT_TOP, VOLT_TOP));

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: ;
        1: apply_settings(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 4'd0, 8'hFF);
        2: apply_settings(16'd1, 16'hFFFF, 16'd0, 16'hFFFF, 4'hF, 8'd0);
        3: apply_settings(16'd1000, 16'd100, 16'd5000, 16'd2000, 4'd3, 8'd23);
        default: begin
          short_v = $urandom_range(0, 2000);
          hot_v = short_v + $urandom_range(0, 5000);
          open_v = hot_v + $urandom_range(0, 30000);
          if (open_v > 65535) open_v = 65535;
          apply_settings(REG_W'($urandom_range(1, 65535)), REG_W'(short_v), REG_W'(open_v),
                         REG_W'(hot_v), RUN_W'($urandom_range(0, 15)),
                         OFF_W'($urandom_range(0, 255)));
        end
      endcase
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 55; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 55; end
        default: begin gap_pct = 31; stall_pct = 31; end
      endcase
      if (p == 3) hold_req <= 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++) send_item(random_reading());
      in_valid <= 1'b0;
    end

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("Sent %0d readings over %0d register settings; %0d results compared, %0d errors.",
             sent, PHASES, checked, fail_cnt);
    $display("Covered short, open with retry, overheat runs, negative and zero denominators.");
    if (fail_cnt == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
